[hw/rtl/hpet_pkg.sv]
// Shared types and constants for the event timer block.
// Used by hpet_tmr, hpet_timer_block, hpet_checker and tb; depends on nothing else.
package hpet_pkg;

    // Timer count and bus widths
    localparam int TIMERS_DEF  = 3;
    localparam int TIMERS_MAX  = 32;
    localparam int IRQ_W       = 3;
    localparam int DATA_W      = 64;
    localparam int OFF_W       = 10;
    localparam int CFG_W       = 10;
    localparam int TIDX_W      = 5;

    // Command codes carried in tuser
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd;

    // Configuration port register indexes
    localparam logic [1:0] CREG_PERIOD   = 2'd0;
    localparam logic [1:0] CREG_VENDOR   = 2'd1;
    localparam logic [1:0] CREG_REVISION = 2'd2;

    localparam logic [26:0] PERIOD_RST   = 27'd69841279;
    localparam logic [15:0] VENDOR_RST   = 16'd0;
    localparam logic [7:0]  REVISION_RST = 8'd1;

    // Register map byte offsets (low three bits always masked)
    localparam logic [OFF_W-1:0] OFF_CAPS   = 10'h000;
    localparam logic [OFF_W-1:0] OFF_GCFG   = 10'h010;
    localparam logic [OFF_W-1:0] OFF_STATUS = 10'h020;
    localparam logic [OFF_W-1:0] OFF_COUNT  = 10'h0F0;
    localparam logic [TIDX_W-1:0] TIM_BASE_IDX = 5'd8;   // 0x100 >> 5
    localparam logic [1:0] SUB_CFG = 2'd0;               // 0x100 + 0x20*n
    localparam logic [1:0] SUB_CMP = 2'd1;               // 0x108 + 0x20*n

    // Timer config bits
    localparam int CB_LEVEL  = 1;
    localparam int CB_ENABLE = 2;
    localparam int CB_PERIOD = 3;
    localparam int CB_VALSET = 6;
    localparam int CB_MODE32 = 8;
    localparam logic [CFG_W-1:0] CFG_WMASK = 10'h14E;
    localparam logic [CFG_W-1:0] CFG_CAPS  = 10'h030;

    // Shared inputs to every timer slice
    typedef struct packed {
        logic              tick;    // enabled tick executes this cycle
        logic [DATA_W-1:0] count;   // counter value after the tick
        logic [DATA_W-1:0] wdata;   // register write value
    } t_tmr_bus;

    // What a timer slice reports back
    typedef struct packed {
        logic              hit;       // comparator matched on this tick
        logic [CFG_W-1:0]  cfg;       // current config
        logic [CFG_W-1:0]  cfg_next;  // config after this item
        logic [DATA_W-1:0] cmp;       // current comparator
    } t_tmr_stat;

endpackage

[hw/rtl/hpet_tmr.sv]
// One comparator timer: config, comparator and period registers with match logic.
// Depends on hpet_pkg.
module hpet_tmr (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_exec,     // an item executes this cycle
    input  hpet_pkg::t_tmr_bus  i_bus,
    input  logic                i_cfg_we,   // config register write
    input  logic                i_cmp_we,   // comparator register write
    output hpet_pkg::t_tmr_stat o_stat
);

    logic [hpet_pkg::CFG_W-1:0]  r_cfg, n_cfg;
    logic [hpet_pkg::DATA_W-1:0] r_cmp, n_cmp;
    logic [hpet_pkg::DATA_W-1:0] r_per, n_per;
    logic                        mode32;
    logic                        hit;
    logic [hpet_pkg::DATA_W-1:0] sum;
    logic [hpet_pkg::DATA_W-1:0] wval;

    assign mode32 = r_cfg[hpet_pkg::CB_MODE32];

    // Match against the advanced counter; low half only in 32-bit mode
    always_comb begin
        if (mode32) begin
            hit = i_bus.tick && (i_bus.count[31:0] == r_cmp[31:0]);
        end else begin
            hit = i_bus.tick && (i_bus.count == r_cmp);
        end
    end

    assign sum  = r_cmp + r_per;
    assign wval = mode32 ? {32'd0, i_bus.wdata[31:0]} : i_bus.wdata;

    // Next-state for the three registers
    always_comb begin
        n_cfg = r_cfg;
        n_cmp = r_cmp;
        n_per = r_per;
        if (hit && r_cfg[hpet_pkg::CB_PERIOD]) begin
            n_cmp = mode32 ? {32'd0, sum[31:0]} : sum;
        end
        if (i_cfg_we) begin
            n_cfg = i_bus.wdata[hpet_pkg::CFG_W-1:0] & hpet_pkg::CFG_WMASK;
        end
        if (i_cmp_we) begin
            if (r_cfg[hpet_pkg::CB_VALSET]) begin
                n_cmp = wval;
                n_cfg[hpet_pkg::CB_VALSET] = 1'b0;
            end else if (r_cfg[hpet_pkg::CB_PERIOD]) begin
                n_per = wval;
            end else begin
                n_cmp = wval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_cmp <= '1;
            r_per <= '0;
        end else if (i_exec) begin
            r_cfg <= n_cfg;
            r_cmp <= n_cmp;
            r_per <= n_per;
        end
    end

    assign o_stat.hit      = hit;
    assign o_stat.cfg      = r_cfg;
    assign o_stat.cfg_next = i_exec ? n_cfg : r_cfg;
    assign o_stat.cmp      = r_cmp;

endmodule

[hw/rtl/hpet_timer_block.sv]
// Event timer top level: stream ports, register map, main counter and timer array.
// Depends on hpet_pkg and hpet_tmr.

// The block takes one item (tick, register read or register write) per clock
// and returns one result per item, in order: the item is held in the input
// register, then executes in a single pass of logic (counter increment, all
// comparator matches, periodic reload, register decode) into the result
// register. A full stream of items is sustained at one per cycle while the
// output side keeps taking results; backpressure on the output holds the
// input after at most one extra item. Ticks only advance the counter while
// the global enable bit is set. The configuration port is always ready and
// should only be written while idle.
module hpet_timer_block #(
    parameter int TIMERS = hpet_pkg::TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,   // [9:0] offset, [73:10] write_data, zero pad
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] command
    // Result output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [63:0] read_data, [66:64] irq_lines, zero pad
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [26:0] i_cfg_data
);

    localparam int DW = hpet_pkg::DATA_W;
    localparam int CW = hpet_pkg::CFG_W;
    localparam int IW = hpet_pkg::IRQ_W;
    localparam int NIRQ = (TIMERS < IW) ? TIMERS : IW;
    localparam logic [4:0] TIMERS_M1 = 5'(TIMERS - 1);

    // Configuration registers
    logic [26:0] r_period_fs;
    logic [15:0] r_vendor;
    logic [7:0]  r_revision;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_fs <= hpet_pkg::PERIOD_RST;
            r_vendor    <= hpet_pkg::VENDOR_RST;
            r_revision  <= hpet_pkg::REVISION_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hpet_pkg::CREG_PERIOD:   r_period_fs <= i_cfg_data;
                hpet_pkg::CREG_VENDOR:   r_vendor    <= i_cfg_data[15:0];
                hpet_pkg::CREG_REVISION: r_revision  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic [73:0] r_in_data;
    logic        out_free;
    logic        exec;

    assign out_free        = !o_m_axis_tvalid || i_m_axis_tready;
    assign exec            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_cmd  <= i_s_axis_tuser;
            r_in_data <= i_s_axis_tdata[73:0];
        end
    end

    // Item decode
    logic [9:0]           off;
    logic [DW-1:0]        wdata;
    logic                 is_tick, is_read, is_write;
    logic                 in_tim;
    logic [4:0]           tidx;
    logic [1:0]           tsub;

    assign off   = {r_in_data[9:3], 3'b000};
    assign wdata = r_in_data[73:10];
    assign in_tim = (off[9:8] != 2'b00);
    assign tidx  = off[9:5] - hpet_pkg::TIM_BASE_IDX;
    assign tsub  = {off[4], off[3]};

    always_comb begin
        is_tick  = 1'b0;
        is_read  = 1'b0;
        is_write = 1'b0;
        case (r_in_cmd)
            hpet_pkg::CMD_TICK:  is_tick  = 1'b1;
            hpet_pkg::CMD_READ:  is_read  = 1'b1;
            hpet_pkg::CMD_WRITE: is_write = 1'b1;
            default: ;
        endcase
    end

    // Global state
    logic [DW-1:0]     r_count, n_count;
    logic [1:0]        r_glb, n_glb;
    logic [TIMERS-1:0] r_status, n_status;
    logic [DW-1:0]     count_inc;
    logic              tick_run;

    assign count_inc = r_count + 64'd1;
    assign tick_run  = exec && is_tick && r_glb[0];

    // Timer array
    hpet_pkg::t_tmr_bus  tbus;
    hpet_pkg::t_tmr_stat tstat [TIMERS];
    logic [TIMERS-1:0]   hits;

    assign tbus.tick  = tick_run;
    assign tbus.count = count_inc;
    assign tbus.wdata = wdata;

    for (genvar g = 0; g < TIMERS; g++) begin : g_tmr
        logic sel;
        assign sel = exec && is_write && in_tim && (tidx == 5'(g));
        hpet_tmr u_tmr (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_exec   (exec),
            .i_bus    (tbus),
            .i_cfg_we (sel && (tsub == hpet_pkg::SUB_CFG)),
            .i_cmp_we (sel && (tsub == hpet_pkg::SUB_CMP)),
            .o_stat   (tstat[g])
        );
        assign hits[g] = tstat[g].hit;
    end

    // Global register updates
    always_comb begin
        n_count  = r_count;
        n_glb    = r_glb;
        n_status = r_status;
        if (tick_run) begin
            n_count  = count_inc;
            n_status = r_status | hits;
        end
        if (exec && is_write) begin
            case (off)
                hpet_pkg::OFF_GCFG:   n_glb = wdata[1:0];
                hpet_pkg::OFF_STATUS: n_status = r_status & ~wdata[TIMERS-1:0];
                hpet_pkg::OFF_COUNT: begin
                    if (!r_glb[0]) begin
                        n_count = wdata;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_glb    <= '0;
            r_status <= '0;
        end else begin
            r_count  <= n_count;
            r_glb    <= n_glb;
            r_status <= n_status;
        end
    end

    // Read mux
    logic [DW-1:0] rd_tim;
    logic [DW-1:0] rdata;

    always_comb begin
        rd_tim = '0;
        for (int i = 0; i < TIMERS; i++) begin
            if (tidx == 5'(i)) begin
                if (tsub == hpet_pkg::SUB_CFG) begin
                    rd_tim = rd_tim | {{(DW-CW){1'b0}}, tstat[i].cfg | hpet_pkg::CFG_CAPS};
                end else if (tsub == hpet_pkg::SUB_CMP) begin
                    rd_tim = rd_tim | tstat[i].cmp;
                end
            end
        end
    end

    always_comb begin
        rdata = '0;
        if (is_read) begin
            case (off)
                hpet_pkg::OFF_CAPS: rdata = {5'd0, r_period_fs, r_vendor, 1'b1, 1'b0,
                                             1'b1, TIMERS_M1, r_revision};
                hpet_pkg::OFF_GCFG:   rdata = {62'd0, r_glb};
                hpet_pkg::OFF_STATUS: rdata = {{(DW-TIMERS){1'b0}}, r_status};
                hpet_pkg::OFF_COUNT:  rdata = r_count;
                default: begin
                    if (in_tim) begin
                        rdata = rd_tim;
                    end
                end
            endcase
        end
    end

    // Interrupt lines from the state after this item
    logic [IW-1:0] irq;

    always_comb begin
        irq = '0;
        for (int i = 0; i < NIRQ; i++) begin
            if (tstat[i].cfg_next[hpet_pkg::CB_ENABLE]) begin
                if (tstat[i].cfg_next[hpet_pkg::CB_LEVEL]) begin
                    irq[i] = n_status[i];
                end else begin
                    irq[i] = hits[i];
                end
            end
        end
    end

    // Result register
    logic       r_out_valid;
    logic [DW-1:0] r_out_rdata;
    logic [IW-1:0] r_out_irq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_rdata <= rdata;
            r_out_irq   <= irq;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_irq, r_out_rdata};

endmodule

[test/hpet_checker.sv]
// Result checker for hpet_timer_block: watches the item, result and configuration
// channels, keeps its own copy of the timer state and compares every result.
// Depends on hpet_pkg.
module hpet_checker
    import hpet_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [79:0] i_s_tdata,   // [9:0] offset, [73:10] write_data, zero pad
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] i_m_tdata,   // [63:0] read_data, [66:64] irq_lines, zero pad
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [26:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_irq_seen
);

    localparam int NTMR = TIMERS_DEF;
    localparam logic [63:0] LOW32 = 64'h0000_0000_FFFF_FFFF;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [IRQ_W-1:0]  irq;
    } t_timer_reply;

    // Capability fields set through the configuration channel
    logic [26:0] tick_fs;
    logic [15:0] vend_code;
    logic [7:0]  rev_id;

    // Predicted timer state
    logic [63:0]      count_q;
    logic [1:0]       gbits;
    logic [NTMR-1:0]  status_q;
    logic [CFG_W-1:0] tcfg [NTMR];
    logic [63:0]      tcmp [NTMR];
    logic [63:0]      tper [NTMR];

    t_timer_reply reply_q[$];
    int fail_cnt  = 0;
    int pend_cnt  = 0;
    int check_cnt = 0;
    int irq_cnt   = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pend_cnt;
    assign o_checked    = check_cnt;
    assign o_irq_seen   = irq_cnt;

    // Register map read
    function automatic logic [63:0] read_reg(input logic [OFF_W-1:0] off);
        logic [TIDX_W-1:0] idx;
        int n;
        read_reg = '0;
        idx = off[9:5];
        case ({off[9:3], 3'b000})
            OFF_CAPS: read_reg = {5'd0, tick_fs, vend_code, 1'b1, 1'b0, 1'b1,
                                  5'(NTMR - 1), rev_id};
            OFF_GCFG:   read_reg = 64'(gbits);
            OFF_STATUS: read_reg = 64'(status_q);
            OFF_COUNT:  read_reg = count_q;
            default: begin
                if (idx >= TIM_BASE_IDX) begin
                    n = int'(idx) - int'(TIM_BASE_IDX);
                    if (n < NTMR) begin
                        if (off[4:3] == SUB_CFG)
                            read_reg = 64'((tcfg[n] & CFG_WMASK) | CFG_CAPS);
                        else if (off[4:3] == SUB_CMP)
                            read_reg = tcmp[n];
                    end
                end
            end
        endcase
    endfunction

    // Register map write
    task automatic write_reg(input logic [OFF_W-1:0] off, input logic [63:0] val);
        logic [TIDX_W-1:0] idx;
        logic [63:0] v;
        int n;
        idx = off[9:5];
        v = val;
        case ({off[9:3], 3'b000})
            OFF_GCFG:   gbits = val[1:0];
            OFF_STATUS: status_q = status_q & ~val[NTMR-1:0];
            OFF_COUNT:  if (!gbits[0]) count_q = val;
            default: begin
                if (idx >= TIM_BASE_IDX) begin
                    n = int'(idx) - int'(TIM_BASE_IDX);
                    if (n < NTMR) begin
                        if (off[4:3] == SUB_CFG) begin
                            tcfg[n] = val[CFG_W-1:0] & CFG_WMASK;
                        end else if (off[4:3] == SUB_CMP) begin
                            if (tcfg[n][CB_MODE32]) v = v & LOW32;
                            // value-set steers one write to the comparator
                            if (tcfg[n][CB_VALSET]) begin
                                tcmp[n] = v;
                                tcfg[n][CB_VALSET] = 1'b0;
                            end else if (tcfg[n][CB_PERIOD]) begin
                                tper[n] = v;
                            end else begin
                                tcmp[n] = v;
                            end
                        end
                    end
                end
            end
        endcase
    endtask

    // Executes one item on the predicted state and gives its result
    task automatic run_timer_item(input logic [1:0] cmd, input logic [OFF_W-1:0] off,
                                  input logic [63:0] wd, output t_timer_reply r);
        logic [IRQ_W-1:0] pulse;
        logic m32;
        logic hit;
        logic [63:0] nxt;
        pulse = '0;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                if (gbits[0]) begin
                    count_q = count_q + 64'd1;
                    for (int i = 0; i < NTMR; i++) begin
                        m32 = tcfg[i][CB_MODE32];
                        hit = m32 ? (count_q[31:0] == tcmp[i][31:0]) : (count_q == tcmp[i]);
                        if (hit) begin
                            status_q[i] = 1'b1;
                            if (i < IRQ_W) pulse[i] = 1'b1;
                            if (tcfg[i][CB_PERIOD]) begin
                                nxt = tcmp[i] + tper[i];
                                tcmp[i] = m32 ? (nxt & LOW32) : nxt;
                            end
                        end
                    end
                end
            end
            CMD_READ:  r.rdata = read_reg({off[9:3], 3'b000});
            CMD_WRITE: write_reg({off[9:3], 3'b000}, wd);
            default: ;
        endcase
        // level lines follow status, edge lines pulse on the matching tick
        for (int i = 0; i < NTMR && i < IRQ_W; i++) begin
            if (tcfg[i][CB_ENABLE])
                r.irq[i] = tcfg[i][CB_LEVEL] ? status_q[i] : pulse[i];
        end
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $error("%s mismatch: expected 0x%h, actual 0x%h", field, exp_v, act_v);
    endtask

    // Channel monitor: config, then results, then new items
    always @(posedge i_clk) begin : monitor
        t_timer_reply want;
        t_timer_reply nxt_reply;
        if (!i_rst_n) begin
            tick_fs   = PERIOD_RST;
            vend_code = VENDOR_RST;
            rev_id    = REVISION_RST;
            count_q   = '0;
            gbits     = '0;
            status_q  = '0;
            for (int i = 0; i < NTMR; i++) begin
                tcfg[i] = '0;
                tcmp[i] = '1;
                tper[i] = '0;
            end
            reply_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CREG_PERIOD:   tick_fs   = i_cfg_data;
                    CREG_VENDOR:   vend_code = i_cfg_data[15:0];
                    CREG_REVISION: rev_id    = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (reply_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $error("result transfer with nothing expected: 0x%h", i_m_tdata);
                end else begin
                    want = reply_q.pop_front();
                    check_cnt++;
                    if (want.irq != '0) irq_cnt++;
                    if (i_m_tdata[63:0] !== want.rdata)
                        note_mismatch("read_data", want.rdata, i_m_tdata[63:0]);
                    if (i_m_tdata[66:64] !== want.irq)
                        note_mismatch("irq_lines", 64'(want.irq), 64'(i_m_tdata[66:64]));
                    if (i_m_tdata[71:67] !== 5'd0)
                        note_mismatch("pad", 64'd0, 64'(i_m_tdata[71:67]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                run_timer_item(i_s_tuser, i_s_tdata[9:0], i_s_tdata[73:10], nxt_reply);
                reply_q.push_back(nxt_reply);
            end
        end
        pend_cnt = reply_q.size();
    end

endmodule

[test/tb.sv]
// Testbench top for hpet_timer_block: clock, reset, item and configuration stimulus
// under several idle/stall mixes, and the final verdict.
// Depends on hpet_pkg, hpet_timer_block and hpet_checker.
module tb;
    import hpet_pkg::*;

    localparam int LIMIT_CYCLES    = 300000;
    localparam int ITEMS_PER_PHASE = 195;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [26:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int irq_seen;
    int src_idle_pct  = 0;
    int dst_stall_pct = 0;
    int items_sent    = 0;
    int cycles        = 0;

    hpet_timer_block #(.TIMERS(TIMERS_DEF)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    hpet_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_irq_seen   (irq_seen)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side backpressure
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= dst_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("[hpet_timer_block] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Byte offset of a timer register
    function automatic logic [OFF_W-1:0] tmr_off(input int t, input logic [1:0] sub);
        logic [TIDX_W-1:0] idx;
        idx = TIM_BASE_IDX + TIDX_W'(t);
        return {idx, sub, 3'b000};
    endfunction

    // One item transfer; called and left at a falling edge
    task automatic send_item(input logic [1:0] cmd, input logic [OFF_W-1:0] off,
                             input logic [63:0] wd);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, wd, off};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_cfg(input logic [1:0] idx, input logic [26:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Program one timer; periodic timers get comparator via value-set, then period
    task automatic arm_timer(input int t, input logic [CFG_W-1:0] bits,
                             input logic [63:0] cmp, input logic [63:0] per,
                             input logic [63:0] junk);
        logic [63:0] cfgw;
        cfgw = (junk & ~64'(CFG_WMASK)) | 64'(bits);
        if (bits[CB_PERIOD]) cfgw[CB_VALSET] = 1'b1;
        send_item(CMD_WRITE, tmr_off(t, SUB_CFG), cfgw);
        send_item(CMD_WRITE, tmr_off(t, SUB_CMP), cmp);
        if (bits[CB_PERIOD]) send_item(CMD_WRITE, tmr_off(t, SUB_CMP), per);
    endtask

    initial begin : stim
        int phase;
        int target;
        int nticks;
        int pick;
        logic [63:0] base;
        logic [63:0] cmp;
        logic [63:0] per;
        logic [CFG_W-1:0] bits;
        logic [OFF_W-1:0] off;
        logic [1:0] cmd;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: capabilities at reset, then at the low extremes
        send_item(CMD_READ, OFF_CAPS, '0);
        drain();
        set_cfg(CREG_PERIOD, 27'd1);
        set_cfg(CREG_VENDOR, 27'd0);
        set_cfg(CREG_REVISION, 27'd1);
        send_item(CMD_READ, OFF_CAPS, '1);
        send_item(CMD_READ, tmr_off(0, SUB_CMP), '0);        // comparator resets to all ones
        send_item(CMD_READ, tmr_off(3, SUB_CMP), '0);        // timer beyond the count
        send_item(CMD_READ, tmr_off(0, 2'd2), '0);           // route register, unmapped
        send_item(CMD_WRITE, OFF_CAPS, '1);                  // read only
        send_item(CMD_WRITE, OFF_COUNT, 64'hFFFF_FFFF_FFFF_FFFD);
        // level timer at the counter wrap, periodic edge timer, 32-bit periodic timer
        bits = '0;
        bits[CB_LEVEL] = 1'b1;
        bits[CB_ENABLE] = 1'b1;
        arm_timer(0, bits, 64'hFFFF_FFFF_FFFF_FFFF, '0, '1);
        bits = '0;
        bits[CB_ENABLE] = 1'b1;
        bits[CB_PERIOD] = 1'b1;
        arm_timer(1, bits, 64'd0, 64'd1, '0);
        bits[CB_MODE32] = 1'b1;
        arm_timer(2, bits, 64'hDEAD_BEEF_0000_0003, 64'h0000_FFFF_FFFF_FFFF, '0);
        send_item(CMD_WRITE, OFF_GCFG, 64'd3);
        repeat (4) send_item(CMD_TICK, '0, '0);
        send_item(CMD_WRITE, OFF_COUNT, 64'd0);              // ignored while enabled
        repeat (2) send_item(CMD_TICK, '1, '1);
        send_item(CMD_READ, OFF_STATUS, '0);
        send_item(CMD_WRITE, OFF_STATUS, 64'd1);             // write one to clear
        send_item(CMD_READ, OFF_COUNT | 10'h7, '0);          // unaligned offset
        send_item(2'd3, OFF_GCFG, '1);                       // unknown command
        send_item(CMD_WRITE, OFF_GCFG, 64'd0);
        send_item(CMD_TICK, '0, '0);                         // tick while disabled

        for (phase = 0; phase < 4; phase++) begin
            drain();
            case (phase)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 61; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 61; end
                default: begin src_idle_pct = 22; dst_stall_pct = 22; end
            endcase
            if (phase == 1) begin
                set_cfg(CREG_PERIOD, 27'd100000000);
                set_cfg(CREG_VENDOR, 27'd65535);
                set_cfg(CREG_REVISION, 27'd255);
            end else if (phase > 1) begin
                set_cfg(CREG_PERIOD, 27'($urandom_range(1, 100000000)));
                set_cfg(CREG_VENDOR, 27'($urandom_range(0, 65535)));
                set_cfg(CREG_REVISION, 27'($urandom_range(1, 255)));
            end
            send_item(CMD_READ, OFF_CAPS, rand64());
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    // Timer run: disable, load counter, arm timers, enable, tick
                    send_item(CMD_WRITE, OFF_GCFG, rand64() & ~64'd1);
                    case ($urandom_range(3))
                        0: base = rand64();
                        1: base = {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(15))};
                        2: base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(15));
                        default: base = 64'($urandom_range(15));
                    endcase
                    send_item(CMD_WRITE, OFF_COUNT, base);
                    for (int t = 0; t < TIMERS_DEF; t++) begin
                        if ($urandom_range(9) < 7) begin
                            bits = '0;
                            bits[CB_LEVEL]  = 1'($urandom_range(1));
                            bits[CB_ENABLE] = ($urandom_range(3) != 0);
                            bits[CB_PERIOD] = 1'($urandom_range(1));
                            bits[CB_MODE32] = 1'($urandom_range(1));
                            cmp = base + 64'($urandom_range(1, 12));
                            per = 64'($urandom_range(1, 6));
                            if (bits[CB_MODE32]) begin
                                cmp[63:32] = $urandom;
                                per[63:32] = $urandom;
                            end
                            arm_timer(t, bits, cmp, per, rand64());
                            if ($urandom_range(3) == 0)
                                send_item(CMD_READ, tmr_off(t, SUB_CFG), rand64());
                        end
                    end
                    send_item(CMD_WRITE, OFF_GCFG, rand64() | 64'd1);
                    nticks = $urandom_range(4, 28);
                    repeat (nticks) begin
                        pick = $urandom_range(99);
                        if (pick < 80)
                            send_item(CMD_TICK, 10'($urandom_range(1023)), rand64());
                        else if (pick < 88)
                            send_item(CMD_READ, $urandom_range(1) ? OFF_STATUS : OFF_COUNT,
                                      rand64());
                        else if (pick < 94)
                            send_item(CMD_WRITE, OFF_STATUS, rand64());
                        else if (pick < 97)
                            send_item(CMD_READ, tmr_off($urandom_range(2), SUB_CMP), rand64());
                        else
                            send_item(CMD_WRITE, OFF_COUNT, rand64());
                    end
                    send_item(CMD_READ, OFF_STATUS, '0);
                    send_item(CMD_WRITE, OFF_STATUS, rand64());
                end else begin
                    // Noise: any command, any offset, any data
                    repeat ($urandom_range(3, 10)) begin
                        cmd = 2'($urandom_range(3));
                        if ($urandom_range(1)) begin
                            off = 10'($urandom_range(1023));
                        end else begin
                            case ($urandom_range(5))
                                0: off = OFF_CAPS;
                                1: off = OFF_GCFG;
                                2: off = OFF_STATUS;
                                3: off = OFF_COUNT;
                                4: off = tmr_off($urandom_range(3), SUB_CFG);
                                default: off = tmr_off($urandom_range(3), SUB_CMP);
                            endcase
                            off[2:0] = 3'($urandom_range(7));
                        end
                        send_item(cmd, off, rand64());
                    end
                end
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        $display("Run covered %0d items (ticks, reads, writes, noise) in four idle/stall mixes",
                 items_sent);
        $display("and several capability settings; %0d results checked, %0d with interrupts up.",
                 checked, irq_seen);
        if (fail_count == 0 && pending == 0)
            $display("[hpet_timer_block] OK");
        else
            $display("[hpet_timer_block] ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/hpet_pkg.sv
hw/rtl/hpet_tmr.sv
hw/rtl/hpet_timer_block.sv
test/hpet_checker.sv
test/tb.sv
